### hw/rtl/plotter_point_move_controller_top_assert.svh
// assertion macros for the plotter point move controller
`ifndef PLOTTER_POINT_MOVE_CONTROLLER_TOP_ASSERT_SVH
`define PLOTTER_POINT_MOVE_CONTROLLER_TOP_ASSERT_SVH

// same-cycle implication
`define PMC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pmc check failed");

// next-cycle implication
`define PMC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pmc check failed");

`endif

### hw/rtl/pmc_pkg.sv
`timescale 1ns / 1ps

package pmc_pkg;

  localparam int ANGLE_ITERATIONS = 16;
  localparam int ATAN_LEN         = 24;
  localparam int CORDIC_STEPS     = (ANGLE_ITERATIONS < ATAN_LEN) ? ANGLE_ITERATIONS : ATAN_LEN;
  localparam int ITER_W           = $clog2(CORDIC_STEPS);

  localparam int XY_W   = 33;
  localparam int Z_W    = 17;
  localparam int PHI_W  = 14;
  localparam int COS_W  = 31;
  localparam int LIM_W  = 7;
  localparam int PROD_W = LIM_W + COS_W;
  localparam int VEC_SHIFT = 12;

  localparam logic signed [XY_W-1:0] ONE_Q30  = XY_W'(64'd1073741824);
  localparam logic signed [XY_W-1:0] CORDIC_K = XY_W'(64'd652032874);
  localparam logic [Z_W-1:0]         QUARTER_TURN = Z_W'(16384);
  localparam logic [LIM_W-1:0]       POWER_CAP = LIM_W'(100);
  localparam logic [LIM_W-1:0]       DRAW_LIMIT_RST = LIM_W'(50);
  localparam logic [LIM_W-1:0]       MOVE_LIMIT_RST = LIM_W'(100);

  // configuration register indexes
  localparam logic REG_DRAW_LIMIT = 1'b0;
  localparam logic REG_MOVE_LIMIT = 1'b1;

  // opcodes
  localparam logic OP_MOVE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic              capture;
    logic              decode;
    logic              step;
    logic              rot;
    logic              angle;
    logic              mul;
    logic              apply;
    logic              emit;
    logic [ITER_W-1:0] iter;
  } pmc_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic zero_len;
    logic phi_zero;
    logic out_free;
  } pmc_status_t;

  // arctangent of 2^-i in binary angle units, full turn = 65536
  function automatic logic [PHI_W-1:0] atan_units(input logic [4:0] idx);
    logic [PHI_W-1:0] val;
    case (idx)
      5'd0:    val = PHI_W'(8192);
      5'd1:    val = PHI_W'(4836);
      5'd2:    val = PHI_W'(2555);
      5'd3:    val = PHI_W'(1297);
      5'd4:    val = PHI_W'(651);
      5'd5:    val = PHI_W'(326);
      5'd6:    val = PHI_W'(163);
      5'd7:    val = PHI_W'(81);
      5'd8:    val = PHI_W'(41);
      5'd9:    val = PHI_W'(20);
      5'd10:   val = PHI_W'(10);
      5'd11:   val = PHI_W'(5);
      5'd12:   val = PHI_W'(3);
      5'd13:   val = PHI_W'(1);
      5'd14:   val = PHI_W'(1);
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

### hw/rtl/pmc_ctrl.sv
`timescale 1ns / 1ps

module pmc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pmc_pkg::pmc_status_t status_i,
  output pmc_pkg::pmc_cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_VEC    = 3'd2;
  localparam logic [2:0] S_ANGLE  = 3'd3;
  localparam logic [2:0] S_ROT    = 3'd4;
  localparam logic [2:0] S_MUL    = 3'd5;
  localparam logic [2:0] S_APPLY  = 3'd6;
  localparam logic [2:0] S_EMIT   = 3'd7;

  logic [2:0]                 state_q, state_d;
  logic [pmc_pkg::ITER_W-1:0] iter_q, iter_d;
  logic                       last_w;

  assign last_w     = (iter_q == pmc_pkg::ITER_W'(pmc_pkg::CORDIC_STEPS - 1));
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    iter_d  = iter_q;
    cmd_o   = '0;
    cmd_o.iter = iter_q;
    unique case (state_q)
      S_IDLE: begin
        iter_d = '0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.decode = 1'b1;
        if (status_i.is_tick || status_i.zero_len) begin
          state_d = S_EMIT;
        end else begin
          state_d = S_VEC;
        end
      end
      S_VEC: begin
        cmd_o.step = 1'b1;
        if (last_w) begin
          iter_d  = '0;
          state_d = S_ANGLE;
        end else begin
          iter_d = iter_q + 1'b1;
        end
      end
      S_ANGLE: begin
        cmd_o.angle = 1'b1;
        state_d = status_i.phi_zero ? S_MUL : S_ROT;
      end
      S_ROT: begin
        cmd_o.step = 1'b1;
        cmd_o.rot  = 1'b1;
        if (last_w) begin
          iter_d  = '0;
          state_d = S_MUL;
        end else begin
          iter_d = iter_q + 1'b1;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d = S_APPLY;
      end
      S_APPLY: begin
        cmd_o.apply = 1'b1;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      iter_q  <= '0;
    end else begin
      state_q <= state_d;
      iter_q  <= iter_d;
    end
  end

endmodule

### hw/rtl/pmc_datapath.sv
`timescale 1ns / 1ps

module pmc_datapath (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic                    cfg_idx_i,
  input  logic [6:0]              cfg_wdata_i,
  input  logic                    opcode_i,
  input  logic signed [15:0]      start_x_i,
  input  logic signed [15:0]      start_y_i,
  input  logic signed [15:0]      target_x_i,
  input  logic signed [15:0]      target_y_i,
  input  logic                    draw_i,
  input  logic signed [15:0]      enc_x_i,
  input  logic signed [15:0]      enc_y_i,
  input  logic                    out_ready_i,
  output logic                    out_valid_o,
  output logic signed [7:0]       power_x_o,
  output logic signed [7:0]       power_y_o,
  output logic                    pen_lowered_o,
  output logic                    busy_res_o,
  output logic                    done_res_o,
  input  pmc_pkg::pmc_cmd_t       cmd_i,
  output pmc_pkg::pmc_status_t    status_o
);

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  // configuration
  logic [pmc_pkg::LIM_W-1:0] draw_lim_q, move_lim_q;

  // captured transaction
  logic               opcode_q, draw_q;
  logic signed [15:0] sx_q, sy_q, tx_q, ty_q, ex_q, ey_q;

  // architectural state
  logic               moving_q, pen_q, done_q;
  logic [1:0]         quad_q;
  logic signed [15:0] goal_x_q, goal_y_q;
  logic signed [7:0]  drive_x_q, drive_y_q;

  // cordic and multiply
  logic signed [pmc_pkg::XY_W-1:0] x_q, y_q;
  logic signed [pmc_pkg::Z_W-1:0]  z_q;
  logic [pmc_pkg::LIM_W-1:0]       lim_q;
  logic [pmc_pkg::PROD_W-1:0]      mc_q, ms_q;

  // output register
  logic              out_valid_q, pen_out_q, busy_out_q, done_out_q;
  logic signed [7:0] px_out_q, py_out_q;

  // decode
  logic signed [16:0] dx_w, dy_w, u_w, v_w;
  logic               dx_pos_w, dy_pos_w, zero_w;
  logic [1:0]         quad_w;
  logic [pmc_pkg::LIM_W-1:0] lim_raw_w, lim_w;

  assign dx_w     = {tx_q[15], tx_q} - {sx_q[15], sx_q};
  assign dy_w     = {ty_q[15], ty_q} - {sy_q[15], sy_q};
  assign dx_pos_w = !dx_w[16] && (dx_w != '0);
  assign dy_pos_w = !dy_w[16] && (dy_w != '0);
  assign zero_w   = (dx_w == '0) && (dy_w == '0);

  always_comb begin
    priority if (dx_pos_w && !dy_w[16]) begin
      quad_w = QUAD_0;
      u_w    = dx_w;
      v_w    = dy_w;
    end else if (!dx_pos_w && dy_pos_w) begin
      quad_w = QUAD_1;
      u_w    = dy_w;
      v_w    = -dx_w;
    end else if (dx_w[16]) begin
      quad_w = QUAD_2;
      u_w    = -dx_w;
      v_w    = -dy_w;
    end else begin
      quad_w = QUAD_3;
      u_w    = -dy_w;
      v_w    = dx_w;
    end
  end

  assign lim_raw_w = draw_q ? draw_lim_q : move_lim_q;
  assign lim_w     = (lim_raw_w > pmc_pkg::POWER_CAP) ? pmc_pkg::POWER_CAP : lim_raw_w;

  // arrival test
  logic xge_w, xle_w, yge_w, yle_w, arrived_w;

  assign xge_w = (ex_q >= goal_x_q);
  assign xle_w = (ex_q <= goal_x_q);
  assign yge_w = (ey_q >= goal_y_q);
  assign yle_w = (ey_q <= goal_y_q);

  always_comb begin
    unique case (quad_q)
      QUAD_0:  arrived_w = xge_w && yge_w;
      QUAD_1:  arrived_w = xle_w && yge_w;
      QUAD_2:  arrived_w = xle_w && yle_w;
      QUAD_3:  arrived_w = xge_w && yle_w;
      default: arrived_w = 1'b0;
    endcase
  end

  // shared cordic micro-rotation
  logic signed [pmc_pkg::XY_W-1:0] xs_w, ys_w, x_step_w, y_step_w;
  logic signed [pmc_pkg::Z_W-1:0]  a_w, z_step_w;
  logic                            ccw_w;

  assign xs_w  = x_q >>> cmd_i.iter;
  assign ys_w  = y_q >>> cmd_i.iter;
  assign a_w   = signed'(pmc_pkg::Z_W'(pmc_pkg::atan_units(5'(cmd_i.iter))));
  assign ccw_w = cmd_i.rot ? !z_q[pmc_pkg::Z_W-1] : y_q[pmc_pkg::XY_W-1];

  assign x_step_w = ccw_w ? (x_q - ys_w) : (x_q + ys_w);
  assign y_step_w = ccw_w ? (y_q + xs_w) : (y_q - xs_w);
  assign z_step_w = ccw_w ? (z_q - a_w)  : (z_q + a_w);

  // angle clamp to one quadrant
  logic [pmc_pkg::PHI_W-1:0] phi_w;

  always_comb begin
    priority if (z_q[pmc_pkg::Z_W-1]) begin
      phi_w = '0;
    end else if (z_q >= signed'(pmc_pkg::QUARTER_TURN)) begin
      phi_w = '1;
    end else begin
      phi_w = z_q[pmc_pkg::PHI_W-1:0];
    end
  end

  // cosine and sine clamp to [0, 1.0]
  logic [pmc_pkg::COS_W-1:0] c_w, s_w;

  always_comb begin
    priority if (x_q[pmc_pkg::XY_W-1]) begin
      c_w = '0;
    end else if (x_q > pmc_pkg::ONE_Q30) begin
      c_w = pmc_pkg::ONE_Q30[pmc_pkg::COS_W-1:0];
    end else begin
      c_w = x_q[pmc_pkg::COS_W-1:0];
    end
    priority if (y_q[pmc_pkg::XY_W-1]) begin
      s_w = '0;
    end else if (y_q > pmc_pkg::ONE_Q30) begin
      s_w = pmc_pkg::ONE_Q30[pmc_pkg::COS_W-1:0];
    end else begin
      s_w = y_q[pmc_pkg::COS_W-1:0];
    end
  end

  logic [7:0] mag_c_w, mag_s_w;

  assign mag_c_w = mc_q[pmc_pkg::PROD_W-1:30];
  assign mag_s_w = ms_q[pmc_pkg::PROD_W-1:30];

  assign status_o.is_tick  = (opcode_q == pmc_pkg::OP_TICK);
  assign status_o.zero_len = zero_w;
  assign status_o.phi_zero = (phi_w == '0);
  assign status_o.out_free = !out_valid_q || out_ready_i;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      draw_lim_q <= pmc_pkg::DRAW_LIMIT_RST;
      move_lim_q <= pmc_pkg::MOVE_LIMIT_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == pmc_pkg::REG_DRAW_LIMIT) begin
        draw_lim_q <= cfg_wdata_i;
      end
      if (cfg_idx_i == pmc_pkg::REG_MOVE_LIMIT) begin
        move_lim_q <= cfg_wdata_i;
      end
    end
  end

  // transaction capture and arithmetic payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      opcode_q <= opcode_i;
      sx_q     <= start_x_i;
      sy_q     <= start_y_i;
      tx_q     <= target_x_i;
      ty_q     <= target_y_i;
      draw_q   <= draw_i;
      ex_q     <= enc_x_i;
      ey_q     <= enc_y_i;
    end
    if (cmd_i.decode) begin
      x_q   <= pmc_pkg::XY_W'({u_w, {pmc_pkg::VEC_SHIFT{1'b0}}});
      y_q   <= pmc_pkg::XY_W'({v_w, {pmc_pkg::VEC_SHIFT{1'b0}}});
      z_q   <= '0;
      lim_q <= lim_w;
    end else if (cmd_i.step) begin
      x_q <= x_step_w;
      y_q <= y_step_w;
      z_q <= z_step_w;
    end else if (cmd_i.angle) begin
      y_q <= '0;
      if (phi_w == '0) begin
        x_q <= pmc_pkg::ONE_Q30;
      end else begin
        x_q <= pmc_pkg::CORDIC_K;
        z_q <= pmc_pkg::Z_W'(phi_w);
      end
    end
    if (cmd_i.mul) begin
      mc_q <= pmc_pkg::PROD_W'(lim_q) * pmc_pkg::PROD_W'(c_w);
      ms_q <= pmc_pkg::PROD_W'(lim_q) * pmc_pkg::PROD_W'(s_w);
    end
  end

  // move state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      moving_q  <= 1'b0;
      pen_q     <= 1'b0;
      done_q    <= 1'b0;
      quad_q    <= QUAD_0;
      goal_x_q  <= '0;
      goal_y_q  <= '0;
      drive_x_q <= '0;
      drive_y_q <= '0;
    end else if (cmd_i.decode) begin
      done_q <= 1'b0;
      if (opcode_q == pmc_pkg::OP_TICK) begin
        if (moving_q && arrived_w) begin
          moving_q  <= 1'b0;
          pen_q     <= 1'b0;
          drive_x_q <= '0;
          drive_y_q <= '0;
          done_q    <= 1'b1;
        end
      end else begin
        goal_x_q <= tx_q;
        goal_y_q <= ty_q;
        if (zero_w) begin
          moving_q  <= 1'b0;
          pen_q     <= 1'b0;
          drive_x_q <= '0;
          drive_y_q <= '0;
          quad_q    <= QUAD_0;
          done_q    <= 1'b1;
        end else begin
          quad_q   <= quad_w;
          pen_q    <= draw_q;
          moving_q <= 1'b1;
        end
      end
    end else if (cmd_i.apply) begin
      unique case (quad_q)
        QUAD_0: begin
          drive_x_q <= mag_c_w;
          drive_y_q <= mag_s_w;
        end
        QUAD_1: begin
          drive_x_q <= 8'd0 - mag_s_w;
          drive_y_q <= mag_c_w;
        end
        QUAD_2: begin
          drive_x_q <= 8'd0 - mag_c_w;
          drive_y_q <= 8'd0 - mag_s_w;
        end
        QUAD_3: begin
          drive_x_q <= mag_s_w;
          drive_y_q <= 8'd0 - mag_c_w;
        end
        default: begin
          drive_x_q <= '0;
          drive_y_q <= '0;
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      px_out_q   <= drive_x_q;
      py_out_q   <= drive_y_q;
      pen_out_q  <= pen_q;
      busy_out_q <= moving_q;
      done_out_q <= done_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign power_x_o     = px_out_q;
  assign power_y_o     = py_out_q;
  assign pen_lowered_o = pen_out_q;
  assign busy_res_o    = busy_out_q;
  assign done_res_o    = done_out_q;

endmodule

### hw/rtl/plotter_point_move_controller_top.sv
// plotter point move controller, one transaction in flight at a time
// encoder tick: decode goes straight to emit, which waits until the result register is free
// move command: vectoring, angle, rotation, multiply and apply, the steps run on the shared cordic unit
// a move whose clamped angle is zero skips the rotation
// a new input can be taken as soon as the result is loaded, even if it is not yet taken
// reset is asynchronous active low: pen up, motors stopped, idle, limits back to 50 and 100
`timescale 1ns / 1ps

`include "plotter_point_move_controller_top_assert.svh"

module plotter_point_move_controller_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [6:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               opcode_i,
  input  logic signed [15:0] start_x_i,
  input  logic signed [15:0] start_y_i,
  input  logic signed [15:0] target_x_i,
  input  logic signed [15:0] target_y_i,
  input  logic               draw_i,
  input  logic signed [15:0] enc_x_i,
  input  logic signed [15:0] enc_y_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [7:0]  power_x_o,
  output logic signed [7:0]  power_y_o,
  output logic               pen_lowered_o,
  output logic               busy_res_o,
  output logic               done_res_o
);

  pmc_pkg::pmc_cmd_t    cmd;
  pmc_pkg::pmc_status_t status;

  pmc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pmc_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .opcode_i      (opcode_i),
    .start_x_i     (start_x_i),
    .start_y_i     (start_y_i),
    .target_x_i    (target_x_i),
    .target_y_i    (target_y_i),
    .draw_i        (draw_i),
    .enc_x_i       (enc_x_i),
    .enc_y_i       (enc_y_i),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .power_x_o     (power_x_o),
    .power_y_o     (power_y_o),
    .pen_lowered_o (pen_lowered_o),
    .busy_res_o    (busy_res_o),
    .done_res_o    (done_res_o),
    .cmd_i         (cmd),
    .status_o      (status)
  );

  // a finished move reports stopped motors, pen up and idle
  `PMC_ASSERT_NOW(a_done_idle, out_valid_o && done_res_o,
    power_x_o == 8'sd0 && power_y_o == 8'sd0 && !pen_lowered_o && !busy_res_o)

  // an idle result never drives the motors
  `PMC_ASSERT_NOW(a_idle_still, out_valid_o && !busy_res_o,
    power_x_o == 8'sd0 && power_y_o == 8'sd0 && !pen_lowered_o)

  // an accepted transaction takes the block out of idle
  `PMC_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)

  // the result register is loaded only when it is free
  `PMC_ASSERT_NOW(a_emit_free, cmd.emit, !out_valid_o || out_ready_i)

endmodule
